[rtl/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[rtl/inc_pkg.sv]
`timescale 1ns / 1ps

package inc_pkg;

    localparam int MAX_ELEMS  = 1024;
    localparam int VALUE_BITS = 10;

    localparam int IN_BITS    = 10;
    localparam int OUT_BITS   = 19;
    localparam int ADDR_BITS  = VALUE_BITS + 1;
    localparam int COUNT_BITS = $clog2(MAX_ELEMS + 1);
    localparam int LEVEL_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = LEVEL_BITS'(VALUE_BITS - 1);
    localparam logic [COUNT_BITS-1:0] MAX_TALLY  = COUNT_BITS'(MAX_ELEMS);
    localparam logic [ADDR_BITS-1:0]  LAST_ADDR  = '1;
    localparam logic [ADDR_BITS:0]    TABLE_WORD = (ADDR_BITS + 1)'(1) << ADDR_BITS;
    localparam logic [OUT_BITS-1:0]   COUNT_MAX  = '1;

    typedef struct packed {
        logic [IN_BITS-1:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [OUT_BITS-1:0] inversion_count;
        logic                overflow;
    } t_out_item;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] addr;
        logic                 even;
    } t_rd_req;

    typedef struct packed {
        logic                  en;
        logic [ADDR_BITS-1:0]  addr;
        logic [COUNT_BITS-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic valid;
        logic overflow;
    } t_emit;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_EMIT
    } t_state;

    // start of the region that holds one level's prefix counts
    function automatic logic [ADDR_BITS-1:0] level_base(input logic [LEVEL_BITS-1:0] level);
        logic [ADDR_BITS:0] full;
        full = TABLE_WORD - (TABLE_WORD >> level);
        return full[ADDR_BITS-1:0];
    endfunction

endpackage

[rtl/inc_count_ram.sv]
`timescale 1ns / 1ps

module inc_count_ram #(
    parameter int ADDR_BITS = 11,
    parameter int DATA_BITS = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr_a,
    input  logic [ADDR_BITS-1:0] i_rd_addr_b,
    output logic [DATA_BITS-1:0] o_rd_data_a,
    output logic [DATA_BITS-1:0] o_rd_data_b,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_data_a;
    logic [DATA_BITS-1:0] r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data_a <= r_mem[i_rd_addr_a];
            r_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_data_a;
    assign o_rd_data_b = r_data_b;

endmodule

[rtl/inc_seq.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module inc_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  inc_pkg::t_in_item i_in,
    output logic              o_in_ready,
    input  logic              i_wr_busy,
    input  logic              i_out_free,
    output inc_pkg::t_rd_req  o_rd,
    output inc_pkg::t_wr_req  o_clr,
    output inc_pkg::t_emit    o_emit
);

    inc_pkg::t_state r_state, n_state;

    logic [inc_pkg::VALUE_BITS-1:0] r_value, n_value;
    logic                           r_last, n_last;
    logic [inc_pkg::LEVEL_BITS-1:0] r_level, n_level;
    logic [inc_pkg::COUNT_BITS-1:0] r_tally, n_tally;
    logic                           r_ovf, n_ovf;
    logic [inc_pkg::ADDR_BITS-1:0]  r_clr_addr, n_clr_addr;

    logic [inc_pkg::VALUE_BITS-1:0] w_prefix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= inc_pkg::S_CLEAR;
            r_level    <= '0;
            r_tally    <= '0;
            r_ovf      <= 1'b0;
            r_clr_addr <= '0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_level    <= n_level;
            r_tally    <= n_tally;
            r_ovf      <= n_ovf;
            r_clr_addr <= n_clr_addr;
            r_last     <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign w_prefix = r_value >> r_level;

    always_comb begin
        n_state    = r_state;
        n_value    = r_value;
        n_last     = r_last;
        n_level    = r_level;
        n_tally    = r_tally;
        n_ovf      = r_ovf;
        n_clr_addr = r_clr_addr;
        o_in_ready = 1'b0;
        o_rd       = '0;
        o_clr      = '0;
        o_emit     = '0;

        unique case (r_state)
            inc_pkg::S_CLEAR: begin
                o_clr.en   = 1'b1;
                o_clr.addr = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == inc_pkg::LAST_ADDR) begin
                    n_state = inc_pkg::S_IDLE;
                end
            end
            inc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_last = i_in.last;
                    if (r_tally == inc_pkg::MAX_TALLY) begin
                        n_ovf = 1'b1;
                        if (i_in.last) begin
                            n_state = inc_pkg::S_EMIT;
                        end
                    end else begin
                        n_tally = r_tally + 1'b1;
                        n_value = i_in.value[inc_pkg::VALUE_BITS-1:0];
                        n_level = '0;
                        n_state = inc_pkg::S_RUN;
                    end
                end
            end
            inc_pkg::S_RUN: begin
                o_rd.valid = 1'b1;
                o_rd.addr  = inc_pkg::level_base(r_level) + inc_pkg::ADDR_BITS'(w_prefix);
                o_rd.even  = !w_prefix[0];
                n_level    = r_level + 1'b1;
                if (r_level == inc_pkg::LAST_LEVEL) begin
                    n_state = r_last ? inc_pkg::S_EMIT : inc_pkg::S_IDLE;
                end
            end
            inc_pkg::S_EMIT: begin
                if (!i_wr_busy && i_out_free) begin
                    o_emit.valid    = 1'b1;
                    o_emit.overflow = r_ovf;
                    n_tally         = '0;
                    n_ovf           = 1'b0;
                    n_clr_addr      = '0;
                    n_state         = inc_pkg::S_CLEAR;
                end
            end
            default: begin
                n_state = inc_pkg::S_CLEAR;
            end
        endcase
    end

    `ASSERT_CLK(a_clr_no_read, i_clk, i_rst_n, o_clr.en |-> !o_rd.valid && !i_wr_busy)
    `ASSERT_CLK(a_tally_bound, i_clk, i_rst_n, r_tally <= inc_pkg::MAX_TALLY)
    `ASSERT_CLK(a_emit_then_clear, i_clk, i_rst_n, o_emit.valid |=> r_state == inc_pkg::S_CLEAR && r_tally == '0)

endmodule

[rtl/inc_update.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module inc_update (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  inc_pkg::t_rd_req               i_rd,
    input  logic [inc_pkg::COUNT_BITS-1:0] i_cnt_lo,
    input  logic [inc_pkg::COUNT_BITS-1:0] i_cnt_hi,
    input  inc_pkg::t_wr_req               i_clr,
    input  logic                           i_total_clr,
    output inc_pkg::t_wr_req               o_wr,
    output logic                           o_busy,
    output logic [inc_pkg::OUT_BITS-1:0]   o_total
);

    localparam int SUM_BITS = ((inc_pkg::COUNT_BITS > inc_pkg::OUT_BITS) ?
                               inc_pkg::COUNT_BITS : inc_pkg::OUT_BITS) + 1;

    logic                          r_wr_valid;
    logic [inc_pkg::ADDR_BITS-1:0] r_wr_addr;
    logic                          r_wr_even;
    logic [inc_pkg::OUT_BITS-1:0]  r_total, n_total;
    logic [SUM_BITS-1:0]           w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
            r_total    <= '0;
        end else begin
            r_wr_valid <= i_rd.valid;
            r_total    <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= i_rd.addr;
        r_wr_even <= i_rd.even;
    end

    // saturating add of the larger neighbors' count
    assign w_sum = SUM_BITS'(r_total) + SUM_BITS'(i_cnt_hi);

    always_comb begin
        n_total = r_total;
        priority if (i_total_clr) begin
            n_total = '0;
        end else if (r_wr_valid && r_wr_even) begin
            if (w_sum > SUM_BITS'(inc_pkg::COUNT_MAX)) begin
                n_total = inc_pkg::COUNT_MAX;
            end else begin
                n_total = w_sum[inc_pkg::OUT_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (r_wr_valid) begin
            o_wr.en   = 1'b1;
            o_wr.addr = r_wr_addr;
            o_wr.data = i_cnt_lo + 1'b1;
        end else begin
            o_wr = i_clr;
        end
    end

    assign o_busy  = r_wr_valid;
    assign o_total = r_total;

    `ASSERT_CLK(a_no_clear_clash, i_clk, i_rst_n, r_wr_valid |-> !i_clr.en && !i_total_clr)

endmodule

[rtl/inversion_counter.sv]
`timescale 1ns / 1ps

// inversion_counter: counts pairs of sequence elements where the earlier one
// is larger than the later one. one item on the input channel carries one
// element and a last flag; one item on the output channel carries the total
// and an overflow flag for each sequence, given on its last element.
// per element: an accept step in S_IDLE, then one S_RUN step per bit level,
// each level reading two prefix counts from the count memory (one read port
// pair) and writing the incremented count back through the write-back stage;
// a new element is taken only once the sequencer is back in S_IDLE.
// the result enters the output register once the last write-back is done
// and the output register is free (with no S_RUN steps if that element is a
// dropped one), then a clearing pass zeroes the count memory, one
// entry a cycle over all 2048 entries, with the input not ready meanwhile.
// after reset the same clearing pass runs before the first item.
// a stalled receiver holds the result in the output register; the block
// keeps taking elements of the next sequence until it has a new result.
// elements beyond MAX_ELEMS are dropped and flag overflow in the result.
module inversion_counter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  inc_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output inc_pkg::t_out_item o_out
);

    // sequencer to memory and update stage
    inc_pkg::t_rd_req w_rd;
    inc_pkg::t_wr_req w_clr;
    inc_pkg::t_wr_req w_wr;
    inc_pkg::t_emit   w_emit;

    logic                           w_wr_busy;
    logic                           w_out_free;
    logic [inc_pkg::COUNT_BITS-1:0] w_cnt_lo;
    logic [inc_pkg::COUNT_BITS-1:0] w_cnt_hi;
    logic [inc_pkg::OUT_BITS-1:0]   w_total;

    // output register
    logic               r_out_valid;
    inc_pkg::t_out_item r_out;

    // room for a new result when empty or being taken this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    inc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .i_wr_busy  (w_wr_busy),
        .i_out_free (w_out_free),
        .o_rd       (w_rd),
        .o_clr      (w_clr),
        .o_emit     (w_emit)
    );

    // prefix p at one port, its odd neighbor p | 1 at the other
    inc_count_ram #(
        .ADDR_BITS (inc_pkg::ADDR_BITS),
        .DATA_BITS (inc_pkg::COUNT_BITS)
    ) u_ram (
        .i_clk       (i_clk),
        .i_rd_en     (w_rd.valid),
        .i_rd_addr_a (w_rd.addr),
        .i_rd_addr_b (w_rd.addr | inc_pkg::ADDR_BITS'(1)),
        .o_rd_data_a (w_cnt_lo),
        .o_rd_data_b (w_cnt_hi),
        .i_wr_en     (w_wr.en),
        .i_wr_addr   (w_wr.addr),
        .i_wr_data   (w_wr.data)
    );

    // write-back stage and running total
    inc_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (w_rd),
        .i_cnt_lo    (w_cnt_lo),
        .i_cnt_hi    (w_cnt_hi),
        .i_clr       (w_clr),
        .i_total_clr (w_emit.valid),
        .o_wr        (w_wr),
        .o_busy      (w_wr_busy),
        .o_total     (w_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload loads only with a fresh result
    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_out.inversion_count <= w_total;
            r_out.overflow        <= w_emit.overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[tb/sv/inversion_checker.sv]
`timescale 1ns / 1ps

module inversion_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  inc_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  inc_pkg::t_out_item i_out,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int VALUE_BITS    = inc_pkg::VALUE_BITS;
    localparam int OUT_BITS      = inc_pkg::OUT_BITS;
    localparam int TABLE_ENTRIES = 1 << (VALUE_BITS + 1);
    localparam int TOTAL_CAP     = (1 << OUT_BITS) - 1;
    localparam int REPORT_LIMIT  = 10;

    int                 prefix_seen [TABLE_ENTRIES];
    longint             pairs_found;
    int                 elems_taken;
    logic               dropped_any;
    inc_pkg::t_out_item totals_due [$];
    int                 mismatches = 0;

    function automatic void restart_sequence();
        foreach (prefix_seen[k]) prefix_seen[k] = 0;
        pairs_found = 0;
        elems_taken = 0;
        dropped_any = 1'b0;
    endfunction

    // per level: earlier elements with prefix one above an even prefix are larger
    function automatic void add_element(input int v);
        int base;
        int span;
        int pfx;
        base = 0;
        for (int lvl = 0; lvl < VALUE_BITS; lvl++) begin
            span = 1 << (VALUE_BITS - lvl);
            pfx  = v >> lvl;
            if ((pfx % 2) == 0 && pfx + 1 < span)
                pairs_found += prefix_seen[base + pfx + 1];
            prefix_seen[base + pfx] += 1;
            base += span;
        end
    endfunction

    function automatic void take_item(input inc_pkg::t_in_item it);
        inc_pkg::t_out_item res;
        if (elems_taken >= inc_pkg::MAX_ELEMS) begin
            dropped_any = 1'b1;
        end else begin
            add_element(int'(it.value) & ((1 << VALUE_BITS) - 1));
            elems_taken++;
        end
        if (it.last) begin
            res.inversion_count = (pairs_found > TOTAL_CAP) ? OUT_BITS'(TOTAL_CAP)
                                                            : OUT_BITS'(pairs_found);
            res.overflow = dropped_any;
            totals_due.insert(totals_due.size(), res);
            restart_sequence();
        end
    endfunction

    function automatic void check_result(input inc_pkg::t_out_item got);
        inc_pkg::t_out_item want;
        if (totals_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected result: count %0d overflow %0b",
                         got.inversion_count, got.overflow);
        end else begin
            want = totals_due.pop_front();
            if (got.inversion_count !== want.inversion_count ||
                got.overflow !== want.overflow) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"result mismatch: expected count %0d overflow %0b, ",
                              "got count %0d overflow %0b"},
                             want.inversion_count, want.overflow,
                             got.inversion_count, got.overflow);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_sequence();
            totals_due.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                take_item(i_in);
            if (i_out_valid && i_out_ready)
                check_result(i_out);
        end
        o_fail_count <= mismatches;
        o_pending    <= totals_due.size();
    end

endmodule

[tb/sv/tb_inversion_counter.sv]
`timescale 1ns / 1ps

module tb_inversion_counter;

    localparam int IN_W         = inc_pkg::IN_BITS;
    // roughly 17 percent idle on each side
    localparam int IDLE_PCT     = 17;
    localparam int RANDOM_ITEMS = 160;
    // idle-free stretch inside the random part, in items
    localparam int STEADY_FROM  = 40;
    localparam int STEADY_TO    = 120;
    // result latency plus one full clearing pass of the count memory
    localparam int DRAIN_CYCLES = 2200;

    // how the values of one sequence are chosen
    typedef enum int {
        PICK_ANY,
        PICK_FEW,
        PICK_EDGE
    } t_pick;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    inc_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    inc_pkg::t_out_item out_item;
    logic               steady    = 1'b0;
    int                 fail_count;
    int                 pending;
    int                 sent      = 0;

    inversion_counter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    // watches both channels, predicts every total and compares
    inversion_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver stalls at random, never inside the steady stretch
    always @(posedge clk) begin
        if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [IN_W-1:0] pick_value(input t_pick how);
        case (how)
            // small clustered set, so equal values show up often
            PICK_FEW: return IN_W'($urandom_range(0, 7)
                                   << $urandom_range(0, IN_W - 3));
            PICK_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return IN_W'(1) << $urandom_range(0, IN_W - 1);
                    default: return ~(IN_W'(1) << $urandom_range(0, IN_W - 1));
                endcase
            end
            default: return IN_W'($urandom);
        endcase
    endfunction

    // random gap with valid low, then hold the item until it is taken
    task automatic send_item(input logic [IN_W-1:0] v, input logic l);
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= '{value: v, last: l};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_sequence(input int len, input t_pick how);
        for (int i = 0; i < len; i++)
            send_item(pick_value(how), i == len - 1);
    endtask

    initial begin
        int   len;
        int   extra;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // single element: no pairs at all
        send_item('0, 1'b1);
        // largest then smallest: one pair
        send_item('1, 1'b0);
        send_item('0, 1'b1);
        // already in order
        send_item('0, 1'b0);
        send_item('1, 1'b1);
        // equal values never count
        send_item('1, 1'b0);
        send_item('1, 1'b1);
        // strictly falling run of five: ten pairs
        send_item(IN_W'(5), 1'b0);
        send_item(IN_W'(4), 1'b0);
        send_item(IN_W'(3), 1'b0);
        send_item(IN_W'(2), 1'b0);
        send_item(IN_W'(1), 1'b1);
        // values that first differ in the top bit
        send_item(IN_W'(512), 1'b0);
        send_item(IN_W'(511), 1'b1);
        // alternating bit patterns
        send_item(IN_W'(10'h155), 1'b0);
        send_item(IN_W'(10'h2AA), 1'b0);
        send_item('0, 1'b1);

        // random sequences, mostly short, some longer
        while (sent < RANDOM_ITEMS) begin
            steady = (sent >= STEADY_FROM && sent < STEADY_TO);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(25, 80);
            else
                len = $urandom_range(1, 16);
            send_sequence(len, t_pick'($urandom_range(0, 2)));
            sent += len;
        end
        steady = 1'b0;

        // full table falling from the top value gives the largest total,
        // then a few more elements that are dropped, the last one among them
        extra = $urandom_range(1, 4);
        for (int k = inc_pkg::MAX_ELEMS - 1; k >= 0; k--)
            send_item(IN_W'(k), 1'b0);
        send_sequence(extra, PICK_ANY);
        // a short sequence right after, to see that the flag was cleared
        send_sequence(3, PICK_ANY);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
